// ----- sv/phcc_pkg.sv -----
// shared types and constants for the packet header checksum checker
package phcc_pkg;

    localparam int WORD_W = 16;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // header word positions
    localparam idx_t POS_SRC_HI  = 3'd0;
    localparam idx_t POS_SRC_LO  = 3'd1;
    localparam idx_t POS_DST_HI  = 3'd2;
    localparam idx_t POS_DST_LO  = 3'd3;
    localparam idx_t POS_SEQ     = 3'd4;
    localparam idx_t POS_CSUM    = 3'd5;
    localparam idx_t POS_LEN     = 3'd6;
    localparam idx_t POS_PAYLOAD = 3'd7;

    // mask applied to a half word: high byte kept, low byte zero
    localparam word_t HALF_MASK = 16'hFF00;

    typedef struct packed {
        word_t word;
        logic  half_word;
        logic  last;
    } item_t;

    typedef struct packed {
        logic  checksum_ok;
        logic  header_complete;
        addr_t source_address;
        addr_t dest_address;
        word_t sequence_number;
        word_t data_length_bits;
    } result_t;

    // 16-bit ones' complement add with end-around carry
    function automatic word_t ones_add(input word_t a, input word_t b);
        logic [WORD_W:0] t;
        begin
            t = {1'b0, a} + {1'b0, b};
            ones_add = t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
        end
    endfunction

endpackage

// ----- sv/phcc_if.sv -----
// request channel interfaces for packet words and check results
interface phcc_in_if;
    import phcc_pkg::*;

    logic  valid;
    logic  ready;
    word_t word;
    logic  half_word;
    logic  last;

    modport source (output valid, output word, output half_word, output last, input ready);
    modport sink (input valid, input word, input half_word, input last, output ready);
endinterface

interface phcc_out_if;
    import phcc_pkg::*;

    logic  valid;
    logic  ready;
    logic  checksum_ok;
    logic  header_complete;
    addr_t source_address;
    addr_t dest_address;
    word_t sequence_number;
    word_t data_length_bits;

    modport source (
        output valid, output checksum_ok, output header_complete, output source_address,
        output dest_address, output sequence_number, output data_length_bits, input ready
    );
    modport sink (
        input valid, input checksum_ok, input header_complete, input source_address,
        input dest_address, input sequence_number, input data_length_bits, output ready
    );
endinterface

// ----- sv/packet_header_checksum_check_top.sv -----
// packet header checksum checker: one 16-bit word per cycle, one result per packet
// a result path: the last word is accepted into the input register, then the result is built into the result register
// throughput: one word per cycle outside stalls, with a combinational 16-bit end-around add
// a waiting result stalls the input only while a packet end sits in the input stage
// reset: rst_n clears both stage valids, the word position and all captured header state
module packet_header_checksum_check_top (
    input  logic    clk,
    input  logic    rst_n,
    phcc_in_if.sink    pkt,
    phcc_out_if.source res
);
    import phcc_pkg::*;

    logic    stage_valid;
    item_t   stage_item;
    logic    can_take;
    logic    advance;
    result_t result;

    // the staged word moves on unless it closes a packet while the output is full
    assign advance = stage_valid && (!stage_item.last || can_take);

    phcc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .pkt         (pkt),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    phcc_hdr_acc u_hdr_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .result  (result)
    );

    phcc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance && stage_item.last),
        .result   (result),
        .can_take (can_take),
        .res      (res)
    );

    // a good checksum is only ever reported on a complete header
    a_ok_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.checksum_ok |-> res.header_complete)
        else $error("checksum_ok without complete header");

    // a packet end blocked by a full output stays in the input stage
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && stage_item.last && res.valid && !res.ready |=> stage_valid)
        else $error("last word lost while output stalled");

    // a new result only appears after a packet end moved on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(advance && stage_item.last))
        else $error("result request without a packet end");
endmodule

// ----- sv/phcc_in_stage.sv -----
// input register stage for incoming packet word requests
module phcc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    phcc_in_if.sink         pkt,
    input  logic            advance,
    output logic            stage_valid,
    output phcc_pkg::item_t stage_item
);
    import phcc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // stage can load when empty or when its content moves on this cycle
    assign pkt.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (pkt.ready)
        begin
            valid_next = pkt.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (pkt.ready && pkt.valid)
        begin
            item_reg <= '{word: pkt.word, half_word: pkt.half_word, last: pkt.last};
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;
endmodule

// ----- sv/phcc_hdr_acc.sv -----
// header capture, running ones' complement sum and result build
module phcc_hdr_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  phcc_pkg::item_t   item,
    output phcc_pkg::result_t result
);
    import phcc_pkg::*;

    word_t sum_reg,  sum_next;
    idx_t  idx_reg,  idx_next;
    word_t csum_reg, csum_next;
    addr_t src_reg,  src_next;
    addr_t dst_reg,  dst_next;
    word_t seq_reg,  seq_next;
    word_t len_reg,  len_next;
    word_t w;
    logic  complete;

    // update of packet state for the word in the stage
    always_comb
    begin
        w         = item.half_word ? (item.word & HALF_MASK) : item.word;
        sum_next  = sum_reg;
        idx_next  = idx_reg;
        csum_next = csum_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        seq_next  = seq_reg;
        len_next  = len_reg;

        case (idx_reg)
            POS_SRC_HI:  src_next[ADDR_W-1:WORD_W] = w;
            POS_SRC_LO:  src_next[WORD_W-1:0]      = w;
            POS_DST_HI:  dst_next[ADDR_W-1:WORD_W] = w;
            POS_DST_LO:  dst_next[WORD_W-1:0]      = w;
            POS_SEQ:     seq_next                  = w;
            POS_CSUM:    csum_next                 = w;
            POS_LEN:     len_next                  = w;
            default:     ;
        endcase

        // checksum word counts as zero
        if (idx_reg != POS_CSUM)
        begin
            sum_next = ones_add(sum_reg, w);
        end

        if (idx_reg != POS_PAYLOAD)
        begin
            idx_next = idx_reg + 3'd1;
        end

        complete = (idx_next == POS_PAYLOAD);

        result.header_complete  = complete;
        result.checksum_ok      = complete && ((~sum_next) == csum_next);
        result.source_address   = src_next;
        result.dest_address     = dst_next;
        result.sequence_number  = seq_next;
        result.data_length_bits = len_next;
    end

    // state registers, cleared at the end of each packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            idx_reg  <= POS_SRC_HI;
            csum_reg <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            seq_reg  <= '0;
            len_reg  <= '0;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                sum_reg  <= '0;
                idx_reg  <= POS_SRC_HI;
                csum_reg <= '0;
                src_reg  <= '0;
                dst_reg  <= '0;
                seq_reg  <= '0;
                len_reg  <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                idx_reg  <= idx_next;
                csum_reg <= csum_next;
                src_reg  <= src_next;
                dst_reg  <= dst_next;
                seq_reg  <= seq_next;
                len_reg  <= len_next;
            end
        end
    end
endmodule

// ----- sv/phcc_out_reg.sv -----
// result register that holds a check result until the request is taken
module phcc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  phcc_pkg::result_t result,
    output logic              can_take,
    phcc_out_if.source        res
);
    import phcc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_take = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_take)
        begin
            valid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (can_take && push)
        begin
            data_reg <= result;
        end
    end

    assign res.valid            = valid_reg;
    assign res.checksum_ok      = data_reg.checksum_ok;
    assign res.header_complete  = data_reg.header_complete;
    assign res.source_address   = data_reg.source_address;
    assign res.dest_address     = data_reg.dest_address;
    assign res.sequence_number  = data_reg.sequence_number;
    assign res.data_length_bits = data_reg.data_length_bits;
endmodule
